FILE: rtl/h3sc_pkg.sv
// Package for the three-set hangul syllable composer.
// Holds widths, key kinds, the phase encoding, the step result struct,
// the double-jamo pair tables and the johab field insert. No dependencies.
package h3sc_pkg;

    localparam int KEY_W      = 8;
    localparam int SYL_W      = 16;
    localparam int JAMO_W     = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map
    localparam logic [APB_ADDR_W-1:0] FILL_CODE_ADDR  = 3'd0;
    localparam logic [SYL_W-1:0]      FILL_CODE_RESET = 16'h8441;

    // key kind, taken from key bits 6:5 (top code marks a key that is ignored)
    typedef enum logic [1:0] {
        KIND_INIT = 2'b00,
        KIND_MED  = 2'b01,
        KIND_FIN  = 2'b10,
        KIND_NONE = 2'b11
    } kind_t;

    // composition phase
    typedef enum logic [6:0] {
        PH_EMPTY = 7'b0000001,
        PH_INIT  = 7'b0000010,
        PH_DINIT = 7'b0000100,
        PH_MED   = 7'b0001000,
        PH_DMED  = 7'b0010000,
        PH_FIN   = 7'b0100000,
        PH_DFIN  = 7'b1000000
    } phase_t;

    // what one key does to the composer state
    typedef struct packed {
        logic             take;      // key is a jamo key, state is updated
        logic             emit;      // finished syllable leaves the block
        logic [SYL_W-1:0] syllable;  // syllable being composed after this key
        phase_t           phase;     // phase after this key
    } step_t;

    // double initial consonants
    function automatic logic [JAMO_W-1:0] pair_init(input logic [KEY_W-1:0] a,
                                                    input logic [KEY_W-1:0] b);
        logic [JAMO_W-1:0] p;
        p = '0;
        unique case ({a, b})
            {8'h82, 8'h82}: p = 5'h03;
            {8'h85, 8'h85}: p = 5'h06;
            {8'h89, 8'h89}: p = 5'h0a;
            {8'h8b, 8'h8b}: p = 5'h0c;
            {8'h8e, 8'h8e}: p = 5'h0f;
            default:        p = '0;
        endcase
        return p;
    endfunction

    // compound vowels
    function automatic logic [JAMO_W-1:0] pair_med(input logic [KEY_W-1:0] a,
                                                   input logic [KEY_W-1:0] b);
        logic [JAMO_W-1:0] p;
        p = '0;
        unique case ({a, b})
            {8'had, 8'ha3}: p = 5'h0e;
            {8'had, 8'ha4}: p = 5'h0f;
            {8'had, 8'hbd}: p = 5'h12;
            {8'hb4, 8'ha7}: p = 5'h15;
            {8'hb4, 8'haa}: p = 5'h16;
            {8'hb4, 8'hbd}: p = 5'h17;
            {8'hbb, 8'hbd}: p = 5'h1c;
            default:        p = '0;
        endcase
        return p;
    endfunction

    // double final consonants
    function automatic logic [JAMO_W-1:0] pair_fin(input logic [KEY_W-1:0] a,
                                                   input logic [KEY_W-1:0] b);
        logic [JAMO_W-1:0] p;
        p = '0;
        unique case ({a, b})
            {8'hc2, 8'hd5}: p = 5'h04;
            {8'hc5, 8'hd8}: p = 5'h06;
            {8'hc5, 8'hdd}: p = 5'h07;
            {8'hc9, 8'hc2}: p = 5'h0a;
            {8'hc9, 8'hd1}: p = 5'h0b;
            {8'hc9, 8'hd3}: p = 5'h0c;
            {8'hc9, 8'hd5}: p = 5'h0d;
            {8'hc9, 8'hdb}: p = 5'h0e;
            {8'hc9, 8'hdc}: p = 5'h0f;
            {8'hc9, 8'hdd}: p = 5'h10;
            {8'hd3, 8'hd5}: p = 5'h14;
            default:        p = '0;
        endcase
        return p;
    endfunction

    // write one johab field: initial 14:10, medial 9:5, final 4:0
    function automatic logic [SYL_W-1:0] put_field(input logic [SYL_W-1:0]  syl,
                                                   input kind_t             kind,
                                                   input logic [JAMO_W-1:0] v);
        logic [SYL_W-1:0] r;
        r = syl;
        unique case (kind)
            KIND_INIT: r[14:10] = v;
            KIND_MED:  r[9:5]   = v;
            KIND_FIN:  r[4:0]   = v;
            KIND_NONE: r        = syl;
        endcase
        return r;
    endfunction

    // single-jamo phase for a key kind
    function automatic phase_t kind_phase(input kind_t kind);
        phase_t ph;
        ph = PH_EMPTY;
        unique case (kind)
            KIND_INIT: ph = PH_INIT;
            KIND_MED:  ph = PH_MED;
            KIND_FIN:  ph = PH_FIN;
            KIND_NONE: ph = PH_EMPTY;
        endcase
        return ph;
    endfunction

endpackage

FILE: rtl/h3sc_if.sv
// Valid/ready channel interfaces of the hangul syllable composer.
// Key channel and syllable channel. Depends on h3sc_pkg.
interface h3sc_key_if
    import h3sc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface h3sc_syl_if
    import h3sc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SYL_W-1:0] syllable_code;

    modport source (output valid, output syllable_code, input ready);
    modport sink   (input valid, input syllable_code, output ready);
endinterface

FILE: rtl/hangul_3set_syllable_composer_top.sv
// Top level of the three-set hangul syllable composer.
// Uses h3sc_pkg, the channel interfaces in h3sc_if.sv and h3sc_step.
//
// Usage
//   key_in carries one keyboard code per word. Codes 0x80-0x9f are initial
//   consonants, 0xa0-0xbf vowels, 0xc0-0xdf final consonants; any other code
//   is taken and dropped without effect. syl_out carries a johab syllable
//   each time a key ends the syllable being composed; most keys give none.
//   The fill_code register (APB byte address 0) is the empty syllable that
//   every new syllable starts from; write it only while the block is idle.
// Timing
//   A key is registered on acceptance and resolved from the key register;
//   the syllable it ends passes through the output register to syl_out.
//   One key per cycle is sustained unless a key that ends a syllable waits
//   on a stalled syl_out; stages are the key register and output register.
// Reset
//   Composer state clears to the empty phase, fill_code returns to 0x8441.
// Stall
//   While syl_out is stalled the block keeps taking keys that produce no
//   syllable; a key that would finish a syllable waits in the key register
//   until the output register is free, and key_in.ready drops behind it.
module hangul_3set_syllable_composer_top
    import h3sc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    h3sc_key_if.sink              key_in,
    h3sc_syl_if.source            syl_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SYL_W-1:0] fill_code_reg;
    logic [KEY_W-1:0] key_reg;
    logic             key_vld_reg;
    logic             key_vld_next;
    logic [SYL_W-1:0] cur_syl_reg;
    logic [KEY_W-1:0] last_key_reg;
    phase_t           phase_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic [SYL_W-1:0] out_syl_reg;
    step_t            step;
    logic             key_acc;
    logic             proc;
    logic             cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == FILL_CODE_ADDR);
    assign prdata = (paddr == FILL_CODE_ADDR)
                    ? {{(APB_DATA_W-SYL_W){1'b0}}, fill_code_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_code_reg <= FILL_CODE_RESET;
        end
        else if (cfg_wr)
        begin
            fill_code_reg <= pwdata[SYL_W-1:0];
        end
    end

    // step logic on the registered key
    h3sc_step u_step (
        .key       (key_reg),
        .last_key  (last_key_reg),
        .cur_syl   (cur_syl_reg),
        .phase     (phase_reg),
        .fill_code (fill_code_reg),
        .step      (step)
    );

    // key register handshake: a key waits only if its syllable cannot leave
    assign proc         = key_vld_reg && (!step.emit || !out_vld_reg || syl_out.ready);
    assign key_in.ready = !key_vld_reg || proc;
    assign key_acc      = key_in.valid && key_in.ready;
    assign key_vld_next = key_acc || (key_vld_reg && !proc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg <= 1'b0;
        end
        else
        begin
            key_vld_reg <= key_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_acc)
        begin
            key_reg <= key_in.key_code;
        end
    end

    // composer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_syl_reg  <= '0;
            last_key_reg <= '0;
            phase_reg    <= PH_EMPTY;
        end
        else if (proc && step.take)
        begin
            cur_syl_reg  <= step.syllable;
            last_key_reg <= key_reg;
            phase_reg    <= step.phase;
        end
    end

    // output register
    assign out_vld_next = (proc && step.emit) || (out_vld_reg && !syl_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && step.emit)
        begin
            out_syl_reg <= cur_syl_reg;
        end
    end

    assign syl_out.valid         = out_vld_reg;
    assign syl_out.syllable_code = out_syl_reg;

    // checks
    a_emit_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && step.emit) |-> (phase_reg != PH_EMPTY))
        else $error("syllable emitted from the empty phase");

    a_emit_value: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && step.emit) |=> (syl_out.valid && syl_out.syllable_code == $past(cur_syl_reg)))
        else $error("emitted syllable differs from the one being composed");

    a_ignored_key: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && !step.take) |=> ($stable(phase_reg) && $stable(cur_syl_reg)
                                  && $stable(last_key_reg)))
        else $error("ignored key changed the composer state");

    a_blocked_key_held: assert property (@(posedge clk) disable iff (!rst_n)
        (key_vld_reg && !proc) |=> (key_vld_reg && $stable(key_reg) && $stable(phase_reg)))
        else $error("waiting key lost or state moved while output stalled");

endmodule

FILE: rtl/h3sc_step.sv
// Next-state logic of the composer for one key: pair lookup and field insert.
// Purely combinational. Depends on h3sc_pkg.
module h3sc_step
    import h3sc_pkg::*;
(
    input  logic [KEY_W-1:0] key,
    input  logic [KEY_W-1:0] last_key,
    input  logic [SYL_W-1:0] cur_syl,
    input  phase_t           phase,
    input  logic [SYL_W-1:0] fill_code,
    output step_t            step
);

    kind_t             kind;
    logic [JAMO_W-1:0] v;
    logic [JAMO_W-1:0] pair;
    logic              join_ok;
    logic              finish;
    logic              extend;
    phase_t            dbl_phase;

    // decode the key
    assign kind = (key[7] == 1'b0) ? KIND_NONE : kind_t'(key[6:5]);
    assign v    = key[JAMO_W-1:0];

    // pair table for the key's own kind
    always_comb
    begin
        pair      = '0;
        dbl_phase = PH_EMPTY;
        unique case (kind)
            KIND_INIT:
            begin
                pair      = pair_init(last_key, key);
                dbl_phase = PH_DINIT;
            end
            KIND_MED:
            begin
                pair      = pair_med(last_key, key);
                dbl_phase = PH_DMED;
            end
            KIND_FIN:
            begin
                pair      = pair_fin(last_key, key);
                dbl_phase = PH_DFIN;
            end
            KIND_NONE:
            begin
                pair      = '0;
                dbl_phase = PH_EMPTY;
            end
        endcase
    end

    // decide join, extend or finish from the phase
    always_comb
    begin
        join_ok = 1'b0;
        finish  = 1'b0;
        extend  = 1'b0;
        unique case (phase)
            PH_INIT:
            begin
                if (kind == KIND_INIT)
                begin
                    join_ok = (pair != '0);
                    finish  = (pair == '0);
                end
                else
                begin
                    extend = 1'b1;
                end
            end
            PH_DINIT:
            begin
                finish = (kind == KIND_INIT);
                extend = (kind != KIND_INIT);
            end
            PH_MED:
            begin
                if (kind == KIND_MED)
                begin
                    join_ok = (pair != '0);
                    finish  = (pair == '0);
                end
                else
                begin
                    finish = (kind == KIND_INIT);
                    extend = (kind == KIND_FIN);
                end
            end
            PH_DMED:
            begin
                extend = (kind == KIND_FIN);
                finish = (kind != KIND_FIN);
            end
            PH_FIN:
            begin
                join_ok = (kind == KIND_FIN) && (pair != '0);
                finish  = !((kind == KIND_FIN) && (pair != '0));
            end
            PH_DFIN:
            begin
                finish = 1'b1;
            end
            PH_EMPTY:
            begin
                finish = 1'b0;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // build the new state
    always_comb
    begin
        step.take = (kind != KIND_NONE);
        step.emit = (kind != KIND_NONE) && finish;
        if (join_ok)
        begin
            step.syllable = put_field(cur_syl, kind, pair);
            step.phase    = dbl_phase;
        end
        else if (extend)
        begin
            step.syllable = put_field(cur_syl, kind, v);
            step.phase    = kind_phase(kind);
        end
        else
        begin
            step.syllable = put_field(fill_code, kind, v);
            step.phase    = kind_phase(kind);
        end
    end

endmodule
